// File: rtl/mnt_pkg.sv
// package for the mac node table: sizes, operation codes and the
// structs passed between the top level and the entry cells
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package mnt_pkg;

    localparam int ENTRIES = 16;
    localparam int SLOT_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int MAC_W   = 48;
    localparam int TIME_W  = 32;
    localparam int SUM_W   = TIME_W + 1;

    localparam logic [1:0] OP_LEARN  = 2'd0;
    localparam logic [1:0] OP_QUERY  = 2'd1;
    localparam logic [1:0] OP_EXPIRE = 2'd2;

    localparam logic [1:0] PORT_A = 2'd0;
    localparam logic [1:0] PORT_B = 2'd1;

    localparam logic [1:0] TYPE_HSR = 2'd0;

    localparam logic [TIME_W-1:0] TIMEOUT_RESET = 32'd1000;

    typedef enum logic {
        ST_IDLE,
        ST_RES
    } t_state;

    // control broadcast to every cell
    typedef struct packed {
        logic              capture;
        logic [MAC_W-1:0]  cap_mac;
        logic [TIME_W-1:0] cap_now;
        logic              commit;
        logic              any_hit;
        logic [1:0]        op;
        logic [MAC_W-1:0]  mac;
        logic [1:0]        port;
        logic [1:0]        ntype;
        logic [TIME_W-1:0] now;
    } t_cell_ctl;

    // priority chain from cell to cell, lowest slot first
    typedef struct packed {
        logic              hit_seen;
        logic              free_seen;
        logic [SLOT_W-1:0] hit_idx;
        logic [SLOT_W-1:0] free_idx;
        logic [1:0]        hit_type;
        logic              hit_aged;
    } t_chain;

endpackage

`default_nettype wire

// File: rtl/mnt_cell.sv
// one table entry: stored mac, type and last-seen times, local compare
// and aging check, and one link of the lowest-slot priority chain
// depends on mnt_pkg
`timescale 1ns / 1ps
`default_nettype none

module mnt_cell (
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    input  mnt_pkg::t_cell_ctl         i_ctl,
    input  wire [mnt_pkg::TIME_W-1:0]  i_timeout,
    input  wire [mnt_pkg::SLOT_W-1:0]  i_slot,
    input  mnt_pkg::t_chain            i_chain,
    output mnt_pkg::t_chain            o_chain
);
    import mnt_pkg::*;

    logic              r_valid;
    logic [MAC_W-1:0]  r_mac;
    logic [1:0]        r_type;
    logic [TIME_W-1:0] r_seen_a;
    logic [TIME_W-1:0] r_seen_b;
    logic              r_hit;
    logic              r_aged;

    logic              take_hit;
    logic              take_free;
    logic              wr_learn;
    logic              wr_claim;
    logic              wr_clear;
    logic [SUM_W-1:0]  sum_a;
    logic [SUM_W-1:0]  sum_b;

    // aging sums at full width, never wrap
    assign sum_a = {1'b0, r_seen_a} + {1'b0, i_timeout};
    assign sum_b = {1'b0, r_seen_b} + {1'b0, i_timeout};

    // chain link: first hit and first free slot win
    assign take_hit  = r_hit & ~i_chain.hit_seen;
    assign take_free = ~r_valid & ~i_chain.free_seen;

    always_comb begin
        o_chain.hit_seen  = i_chain.hit_seen | r_hit;
        o_chain.free_seen = i_chain.free_seen | ~r_valid;
        o_chain.hit_idx   = i_chain.hit_idx | (take_hit ? i_slot : '0);
        o_chain.free_idx  = i_chain.free_idx | (take_free ? i_slot : '0);
        o_chain.hit_type  = i_chain.hit_type | (take_hit ? r_type : 2'b00);
        o_chain.hit_aged  = i_chain.hit_aged | (take_hit & r_aged);
    end

    // write decisions on commit
    assign wr_claim = i_ctl.commit && (i_ctl.op == OP_LEARN) && !i_ctl.any_hit && take_free;
    assign wr_learn = i_ctl.commit && (i_ctl.op == OP_LEARN) && (take_hit || wr_claim);
    assign wr_clear = i_ctl.commit && (i_ctl.op == OP_EXPIRE) && take_hit && r_aged;

    // valid bit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (wr_claim) begin
            r_valid <= 1'b1;
        end else if (wr_clear) begin
            r_valid <= 1'b0;
        end
    end

    // entry payload
    always_ff @(posedge i_clk) begin
        if (wr_learn) begin
            r_mac  <= i_ctl.mac;
            r_type <= i_ctl.ntype;
            if (i_ctl.port == PORT_A) begin
                r_seen_a <= i_ctl.now;
            end else if (wr_claim) begin
                r_seen_a <= '0;
            end
            if (i_ctl.port == PORT_B) begin
                r_seen_b <= i_ctl.now;
            end else if (wr_claim) begin
                r_seen_b <= '0;
            end
        end
    end

    // compare and aging flags, sampled when a word is taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hit  <= 1'b0;
            r_aged <= 1'b0;
        end else if (i_ctl.capture) begin
            r_hit  <= r_valid && (r_mac == i_ctl.cap_mac);
            r_aged <= (sum_a <= {1'b0, i_ctl.cap_now}) && (sum_b <= {1'b0, i_ctl.cap_now});
        end
    end

endmodule

`default_nettype wire

// File: rtl/mac_node_table_with_aging.sv
// mac node table with aging: row of entry cells, command sequencer,
// timeout register and result register
// the input stalls from the taken word until its result word is written to the output register;
// each cell compares and checks aging when a word is taken, the cell chain settles slot choice
//   and updates the table in the result state, which waits while the output register is held
//   by a stalled receiver
// reset (synchronous, active low): all entries invalid, timeout 1000 ticks
// depends on mnt_pkg, mnt_cell
`timescale 1ns / 1ps
`default_nettype none

module mac_node_table_with_aging (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  wire                         i_cfg_we,
    input  wire [mnt_pkg::TIME_W-1:0]   i_cfg_wdata,
    input  wire                         i_in_valid,
    output logic                        o_in_stall,
    input  wire [1:0]                   i_operation,
    input  wire [mnt_pkg::MAC_W-1:0]    i_mac,
    input  wire [1:0]                   i_port,
    input  wire [1:0]                   i_node_type,
    input  wire [mnt_pkg::TIME_W-1:0]   i_now,
    output logic                        o_out_valid,
    input  wire                         i_out_stall,
    output logic                        o_ok,
    output logic                        o_found,
    output logic [3:0]                  o_index,
    output logic [1:0]                  o_type_out,
    output logic                        o_removed,
    output logic [mnt_pkg::SUM_W-1:0]   o_expire_at
);
    import mnt_pkg::*;

    t_state            r_state;
    t_state            n_state;
    logic [TIME_W-1:0] r_timeout;
    logic [1:0]        r_op;
    logic [MAC_W-1:0]  r_mac;
    logic [1:0]        r_port;
    logic [1:0]        r_ntype;
    logic [TIME_W-1:0] r_now;

    logic              r_out_valid;
    logic              r_ok;
    logic              r_found;
    logic [3:0]        r_index;
    logic [1:0]        r_type_out;
    logic              r_removed;
    logic [SUM_W-1:0]  r_expire_at;

    logic              accept;
    logic              commit;
    t_cell_ctl         ctl;
    t_chain            w_chain [ENTRIES+1];
    t_chain            tail;

    logic              is_learn;
    logic              n_ok;
    logic              n_found;
    logic [SLOT_W-1:0] n_slot;
    logic [SLOT_W+3:0] slot_ext;
    logic [1:0]        n_type_out;
    logic              n_removed;
    logic [SUM_W-1:0]  n_expire_at;

    // timeout register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout <= TIMEOUT_RESET;
        end else if (i_cfg_we) begin
            r_timeout <= i_cfg_wdata;
        end
    end

    // sequencer state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // sequencer next state and strobes
    always_comb begin
        n_state    = r_state;
        accept     = 1'b0;
        commit     = 1'b0;
        o_in_stall = 1'b1;
        unique case (r_state)
            ST_IDLE: begin
                o_in_stall = 1'b0;
                accept     = i_in_valid;
                if (i_in_valid) begin
                    n_state = ST_RES;
                end
            end
            ST_RES: begin
                commit = !r_out_valid || !i_out_stall;
                if (commit) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // held input word
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op    <= i_operation;
            r_mac   <= i_mac;
            r_port  <= i_port;
            r_ntype <= i_node_type;
            r_now   <= i_now;
        end
    end

    // broadcast control
    always_comb begin
        ctl.capture = accept;
        ctl.cap_mac = i_mac;
        ctl.cap_now = i_now;
        ctl.commit  = commit;
        ctl.any_hit = tail.hit_seen;
        ctl.op      = r_op;
        ctl.mac     = r_mac;
        ctl.port    = r_port;
        ctl.ntype   = r_ntype;
        ctl.now     = r_now;
    end

    // row of entry cells
    assign w_chain[0] = '0;

    for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
        mnt_cell u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_ctl     (ctl),
            .i_timeout (r_timeout),
            .i_slot    (SLOT_W'(g)),
            .i_chain   (w_chain[g]),
            .o_chain   (w_chain[g+1])
        );
    end

    assign tail = w_chain[ENTRIES];

    // result word from the chain tail
    always_comb begin
        is_learn    = (r_op == OP_LEARN);
        n_ok        = !(is_learn && !tail.hit_seen && !tail.free_seen);
        n_found     = tail.hit_seen &&
                      (r_op == OP_LEARN || r_op == OP_QUERY || r_op == OP_EXPIRE);
        n_slot      = '0;
        if (n_found) begin
            n_slot = tail.hit_idx;
        end else if (is_learn && tail.free_seen) begin
            n_slot = tail.free_idx;
        end
        slot_ext    = {4'b0000, n_slot};
        n_type_out  = (r_op == OP_QUERY && tail.hit_seen) ? tail.hit_type : TYPE_HSR;
        n_removed   = (r_op == OP_EXPIRE) && tail.hit_seen && tail.hit_aged;
        n_expire_at = (is_learn && n_ok) ? ({1'b0, r_now} + {1'b0, r_timeout}) : '0;
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (commit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (commit) begin
            r_ok        <= n_ok;
            r_found     <= n_found;
            r_index     <= slot_ext[3:0];
            r_type_out  <= n_type_out;
            r_removed   <= n_removed;
            r_expire_at <= n_expire_at;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_ok        = r_ok;
    assign o_found     = r_found;
    assign o_index     = r_index;
    assign o_type_out  = r_type_out;
    assign o_removed   = r_removed;
    assign o_expire_at = r_expire_at;

    // checks
    a_commit_in_res: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        commit |-> (r_state == ST_RES))
        else $error("table update outside result state");

    a_accept_then_res: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state == ST_RES))
        else $error("taken word did not move to result state");

    a_removed_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_removed) |-> r_found)
        else $error("removal reported without a match");

    a_full_no_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_ok) |-> (!r_found && r_expire_at == '0))
        else $error("full-table result carries data");

    a_new_word_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        commit |=> r_out_valid)
        else $error("result word lost after update");

endmodule

`default_nettype wire

// File: verif/mac_node_table_with_aging_test.sv
// testbench for mac_node_table_with_aging: drives learn, query, expire and unused words,
// predicts every reply from its own copy of the table and checks them in order
// depends on mnt_pkg and the rtl of mac_node_table_with_aging
`timescale 1ns / 1ps

module mac_node_table_with_aging_test;
    import mnt_pkg::*;

    localparam logic [1:0] OP_UNUSED  = 2'd3;
    localparam logic [1:0] PORT_OTHER = 2'd2;
    localparam logic [1:0] PORT_SPARE = 2'd3;

    localparam logic [TIME_W-1:0] TIMEOUT_MIN = 32'd1;
    localparam logic [TIME_W-1:0] TIMEOUT_MAX = 32'hFFFF_FFFF;
    localparam logic [MAC_W-1:0]  MAC_ONES    = 48'hFFFF_FFFF_FFFF;
    localparam logic [TIME_W-1:0] TICKS_MAX   = 32'hFFFF_FFFF;

    localparam int MAC_POOL_SIZE  = 24;
    localparam int WATCHDOG_LIMIT = 1000;

    // one reply word as seen on the output ports
    typedef struct packed {
        logic             ok;
        logic             found;
        logic [3:0]       index;
        logic [1:0]       type_out;
        logic             removed;
        logic [SUM_W-1:0] expire_at;
    } t_node_reply;

    // block ports
    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_cfg_we = 1'b0;
    logic [TIME_W-1:0] i_cfg_wdata = '0;
    logic              i_in_valid = 1'b0;
    logic              o_in_stall;
    logic [1:0]        i_operation = OP_LEARN;
    logic [MAC_W-1:0]  i_mac = '0;
    logic [1:0]        i_port = PORT_A;
    logic [1:0]        i_node_type = TYPE_HSR;
    logic [TIME_W-1:0] i_now = '0;
    logic              o_out_valid;
    logic              i_out_stall = 1'b0;
    logic              o_ok;
    logic              o_found;
    logic [3:0]        o_index;
    logic [1:0]        o_type_out;
    logic              o_removed;
    logic [SUM_W-1:0]  o_expire_at;

    // predicted table contents
    logic              node_valid [ENTRIES];
    logic [MAC_W-1:0]  node_mac [ENTRIES];
    logic [1:0]        node_kind [ENTRIES];
    logic [TIME_W-1:0] seen_a_ticks [ENTRIES];
    logic [TIME_W-1:0] seen_b_ticks [ENTRIES];
    logic [TIME_W-1:0] aging_timeout = TIMEOUT_RESET;

    t_node_reply       pending_replies [$];
    logic [MAC_W-1:0]  mac_pool [MAC_POOL_SIZE];
    logic [TIME_W-1:0] sim_ticks = 32'd2000;
    logic              no_idle = 1'b0;
    int                mismatches = 0;
    int                quiet_cycles = 0;

    mac_node_table_with_aging DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_operation (i_operation),
        .i_mac       (i_mac),
        .i_port      (i_port),
        .i_node_type (i_node_type),
        .i_now       (i_now),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_ok        (o_ok),
        .o_found     (o_found),
        .o_index     (o_index),
        .o_type_out  (o_type_out),
        .o_removed   (o_removed),
        .o_expire_at (o_expire_at)
    );

    always #4 i_clk = ~i_clk;

    // table update and reply for one accepted request word
    function automatic t_node_reply predict_table_reply(
        input logic [1:0]        op,
        input logic [MAC_W-1:0]  mac,
        input logic [1:0]        port,
        input logic [1:0]        ntype,
        input logic [TIME_W-1:0] now
    );
        t_node_reply      r;
        int               hit;
        int               slot;
        logic [SUM_W-1:0] due_a;
        logic [SUM_W-1:0] due_b;
        r = '0;
        r.ok = 1'b1;
        r.type_out = TYPE_HSR;
        hit = -1;
        for (int i = 0; i < ENTRIES; i++) begin
            if (hit < 0 && node_valid[i] && node_mac[i] == mac) begin
                hit = i;
            end
        end
        if (hit >= 0 && op != OP_UNUSED) begin
            r.found = 1'b1;
            r.index = 4'(hit);
        end
        case (op)
            OP_LEARN: begin
                slot = hit;
                // claim the lowest free slot for a new node
                if (slot < 0) begin
                    for (int i = 0; i < ENTRIES; i++) begin
                        if (slot < 0 && !node_valid[i]) begin
                            slot = i;
                        end
                    end
                    if (slot < 0) begin
                        r.ok = 1'b0;
                    end else begin
                        node_valid[slot] = 1'b1;
                        seen_a_ticks[slot] = '0;
                        seen_b_ticks[slot] = '0;
                        r.index = 4'(slot);
                    end
                end
                if (slot >= 0) begin
                    node_mac[slot] = mac;
                    node_kind[slot] = ntype;
                    if (port == PORT_A) begin
                        seen_a_ticks[slot] = now;
                    end else if (port == PORT_B) begin
                        seen_b_ticks[slot] = now;
                    end
                    r.expire_at = {1'b0, now} + {1'b0, aging_timeout};
                end
            end
            OP_QUERY: begin
                if (hit >= 0) begin
                    r.type_out = node_kind[hit];
                end
            end
            OP_EXPIRE: begin
                // both ports must have aged out, sums at 33 bits
                if (hit >= 0) begin
                    due_a = {1'b0, seen_a_ticks[hit]} + {1'b0, aging_timeout};
                    due_b = {1'b0, seen_b_ticks[hit]} + {1'b0, aging_timeout};
                    if (due_a <= {1'b0, now} && due_b <= {1'b0, now}) begin
                        node_valid[hit] = 1'b0;
                        r.removed = 1'b1;
                    end
                end
            end
            default: begin
            end
        endcase
        return r;
    endfunction

    // predict on every accepted request word
    always @(posedge i_clk) begin
        if (i_rst_n && i_in_valid && !o_in_stall) begin
            pending_replies.push_back(predict_table_reply(i_operation, i_mac, i_port,
                                                          i_node_type, i_now));
        end
    end

    task automatic report_mismatch(input string field_name, input logic [SUM_W-1:0] want,
                                   input logic [SUM_W-1:0] got);
        $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h",
                 $time, field_name, want, got);
        mismatches++;
    endtask

    // compare each accepted reply word with the oldest prediction
    always @(posedge i_clk) begin
        t_node_reply want;
        t_node_reply got;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            got = {o_ok, o_found, o_index, o_type_out, o_removed, o_expire_at};
            if (pending_replies.size() == 0) begin
                $display("%0t: reply word with nothing pending, expected none, actual 0x%0h",
                         $time, got);
                mismatches++;
            end else begin
                want = pending_replies.pop_front();
                if (got.ok !== want.ok)
                    report_mismatch("ok", SUM_W'(want.ok), SUM_W'(got.ok));
                if (got.found !== want.found)
                    report_mismatch("found", SUM_W'(want.found), SUM_W'(got.found));
                if (got.index !== want.index)
                    report_mismatch("index", SUM_W'(want.index), SUM_W'(got.index));
                if (got.type_out !== want.type_out)
                    report_mismatch("type_out", SUM_W'(want.type_out),
                                    SUM_W'(got.type_out));
                if (got.removed !== want.removed)
                    report_mismatch("removed", SUM_W'(want.removed), SUM_W'(got.removed));
                if (got.expire_at !== want.expire_at)
                    report_mismatch("expire_at", want.expire_at, got.expire_at);
            end
        end
    end

    // receiver stalls in random bursts, none in the full-rate tail
    initial begin
        int hold;
        forever begin
            if (no_idle) begin
                i_out_stall <= 1'b0;
                @(posedge i_clk);
            end else begin
                hold = $urandom_range(1, 12);
                i_out_stall <= ($urandom_range(0, 2) == 0);
                repeat (hold) @(posedge i_clk);
            end
        end
    end

    // watchdog on cycles without any word moving
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)
            || i_cfg_we) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("mac_node_table_with_aging_test: FAIL");
            $finish;
        end
    end

    // present one request word and hold it until taken
    task automatic send_frame_event(input logic [1:0] op, input logic [MAC_W-1:0] mac,
                                    input logic [1:0] port, input logic [1:0] ntype,
                                    input logic [TIME_W-1:0] now);
        i_in_valid <= 1'b1;
        i_operation <= op;
        i_mac <= mac;
        i_port <= port;
        i_node_type <= ntype;
        i_now <= now;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
    endtask

    task automatic pause_sender(input int cycles);
        i_in_valid <= 1'b0;
        repeat (cycles) @(posedge i_clk);
    endtask

    // stop sending until every predicted reply has arrived
    task automatic wait_replies_drained();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_replies.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_aging_timeout(input logic [TIME_W-1:0] ticks);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= ticks;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        aging_timeout = ticks;
    endtask

    // random word: mostly known nodes so entries get relearned and aged out
    task automatic send_random_event(input int step_max);
        int               pick;
        logic [1:0]       op;
        logic [1:0]       port;
        logic [MAC_W-1:0] mac;
        logic [63:0]      wide;
        if (!no_idle && $urandom_range(0, 9) == 0) begin
            pause_sender($urandom_range(1, 12));
        end
        pick = $urandom_range(0, 99);
        op = (pick < 45) ? OP_LEARN : (pick < 65) ? OP_QUERY : (pick < 96) ? OP_EXPIRE
                                                                            : OP_UNUSED;
        pick = $urandom_range(0, 99);
        port = (pick < 40) ? PORT_A : (pick < 80) ? PORT_B : (pick < 92) ? PORT_OTHER
                                                                          : PORT_SPARE;
        wide = {$urandom(), $urandom()};
        mac = ($urandom_range(0, 9) == 0) ? wide[MAC_W-1:0]
                                          : mac_pool[$urandom_range(0, MAC_POOL_SIZE - 1)];
        if ($urandom_range(0, 24) == 0) begin
            sim_ticks = $urandom();
        end else begin
            sim_ticks = sim_ticks + $urandom_range(0, step_max);
        end
        send_frame_event(op, mac, port, 2'($urandom_range(0, 3)), sim_ticks);
    endtask

    task automatic run_aging_phase(input logic [TIME_W-1:0] ticks, input int words,
                                   input int step_max);
        wait_replies_drained();
        write_aging_timeout(ticks);
        repeat (words) send_random_event(step_max);
    endtask

    // first and repeated learn, query hit and miss, ignored code, aging edge
    task automatic test_learn_query_expire();
        send_frame_event(OP_LEARN, mac_pool[1], PORT_A, TYPE_HSR, '0);
        send_frame_event(OP_LEARN, mac_pool[0], PORT_B, 2'd3, TICKS_MAX);
        send_frame_event(OP_QUERY, mac_pool[0], PORT_A, TYPE_HSR, 32'd7);
        send_frame_event(OP_QUERY, mac_pool[5], PORT_A, TYPE_HSR, 32'd7);
        send_frame_event(OP_LEARN, mac_pool[1], PORT_OTHER, 2'd2, 32'd5);
        send_frame_event(OP_LEARN, mac_pool[1], PORT_SPARE, 2'd1, 32'd6);
        send_frame_event(OP_UNUSED, mac_pool[1], PORT_A, 2'd3, 32'd8);
        send_frame_event(OP_QUERY, mac_pool[1], PORT_B, TYPE_HSR, 32'd9);
        send_frame_event(OP_EXPIRE, mac_pool[1], PORT_A, TYPE_HSR, 32'd999);
        send_frame_event(OP_EXPIRE, mac_pool[1], PORT_A, TYPE_HSR, 32'd1000);
        send_frame_event(OP_EXPIRE, mac_pool[6], PORT_A, TYPE_HSR, TICKS_MAX);
        send_frame_event(OP_QUERY, mac_pool[1], PORT_A, TYPE_HSR, 32'd1001);
    endtask

    // timeout extremes: expiry time needs the carry bit, aging never reached
    task automatic test_timeout_extremes();
        wait_replies_drained();
        write_aging_timeout(TIMEOUT_MAX);
        send_frame_event(OP_LEARN, mac_pool[2], PORT_A, 2'd2, TICKS_MAX);
        send_frame_event(OP_EXPIRE, mac_pool[2], PORT_B, TYPE_HSR, TICKS_MAX);
        wait_replies_drained();
        write_aging_timeout(TIMEOUT_MIN);
        send_frame_event(OP_EXPIRE, mac_pool[2], PORT_B, TYPE_HSR, TICKS_MAX);
    endtask

    // fill every free slot, then one more learn must be refused
    task automatic test_table_full();
        for (int i = 3; i < 17; i++) begin
            send_frame_event(OP_LEARN, mac_pool[i], 2'(i % 2), 2'(i % 4), 32'(i * 3));
        end
        send_frame_event(OP_LEARN, mac_pool[17], PORT_A, 2'd1, 32'd100);
    endtask

    task automatic test_random_aging();
        run_aging_phase(TIMEOUT_MIN, 150, 4);
        run_aging_phase(32'd37, 180, 40);
        run_aging_phase(TIMEOUT_MAX, 80, 1000);
        run_aging_phase(32'd5000, 180, 3000);
        run_aging_phase(32'($urandom_range(2, 200000)), 150, int'(aging_timeout / 2) + 1);
    endtask

    // last stretch at full rate on both sides
    task automatic test_full_rate_tail();
        wait_replies_drained();
        no_idle = 1'b1;
        write_aging_timeout(TIMEOUT_RESET);
        repeat (200) send_random_event(700);
    endtask

    initial begin
        logic [63:0] wide;
        for (int i = 0; i < ENTRIES; i++) begin
            node_valid[i] = 1'b0;
            node_mac[i] = '0;
            node_kind[i] = TYPE_HSR;
            seen_a_ticks[i] = '0;
            seen_b_ticks[i] = '0;
        end
        for (int i = 0; i < MAC_POOL_SIZE; i++) begin
            wide = {$urandom(), $urandom()};
            mac_pool[i] = wide[MAC_W-1:0];
        end
        mac_pool[0] = MAC_ONES;
        mac_pool[1] = '0;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_learn_query_expire();
        test_timeout_extremes();
        test_table_full();
        test_random_aging();
        test_full_rate_tail();

        wait_replies_drained();
        repeat (8) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("mac_node_table_with_aging_test: PASS");
        end else begin
            $display("mac_node_table_with_aging_test: FAIL");
        end
        $finish;
    end

endmodule
